>>> sv/kufef_pkg.sv
// Package for the Kruskal union-find edge filter.
// Holds widths, the node count, command codes and the node index cast.
// No dependencies.
package kufef_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = 10;
  localparam int COST_W     = 16;
  localparam int TOTAL_W    = 32;
  localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
    return ADDR_W'(n);
  endfunction

endpackage

>>> sv/kufef_if.sv
// Request and result channel interfaces of the edge filter.
// Depends on kufef_pkg for field widths.
interface kufef_edge_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [kufef_pkg::NODE_W-1:0]  node_a;
  logic [kufef_pkg::NODE_W-1:0]  node_b;
  logic [kufef_pkg::COST_W-1:0]  edge_cost;
  logic                          keep_if_cycle;

  modport source (output valid, command, node_a, node_b, edge_cost, keep_if_cycle,
                  input ready);
  modport sink   (input valid, command, node_a, node_b, edge_cost, keep_if_cycle,
                  output ready);
endinterface

interface kufef_result_if;
  logic                          valid;
  logic                          ready;
  logic                          edge_emitted;
  logic                          components_joined;
  logic [kufef_pkg::NODE_W-1:0]  out_node_a;
  logic [kufef_pkg::NODE_W-1:0]  out_node_b;
  logic [kufef_pkg::TOTAL_W-1:0] total_cost;

  modport source (output valid, edge_emitted, components_joined, out_node_a,
                  out_node_b, total_cost, input ready);
  modport sink   (input valid, edge_emitted, components_joined, out_node_a,
                  out_node_b, total_cost, output ready);
endinterface

>>> sv/kufef_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kufef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
// Top level of the Kruskal union-find edge filter with path-halving root search.
// Depends on kufef_pkg, kufef_if (kufef_edge_if, kufef_result_if) and kufef_ram.
//
//   channel     dir  handshake     payload
//   in_edge     in   valid/ready   command, node_a, node_b, edge_cost, keep_if_cycle
//   out_result  out  valid/ready   edge_emitted, components_joined, out_node_a,
//                                  out_node_b, total_cost
//   cfg         in   cfg_we        cfg_wdata (natural_mode)
//
// An edge request runs from its acceptance through S_WT_V and S_WT_P for the halving
// steps of both root searches, then S_OUT; parent memory reads are registered.
// After reset and after each clear request a sweep writes the identity into all
// NODE_COUNT (1024) parent memory entries, and no request is taken meanwhile.
// A new request is taken while the previous result waits; a stalled result holds
// the block in its result state.
module kruskal_union_find_edge_filter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  kufef_edge_if.sink             in_edge,
  kufef_result_if.source         out_result
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WT_V,
    S_WT_P,
    S_OUT
  } state_t;

  state_t                          state;
  logic [kufef_pkg::ADDR_W-1:0]    clr_cnt;
  logic                            sweep_after;
  logic                            natural_mode;
  logic [kufef_pkg::TOTAL_W-1:0]   cost_total;
  logic                            phase;
  logic [kufef_pkg::NODE_W-1:0]    v;
  logic [kufef_pkg::NODE_W-1:0]    ra;
  logic [kufef_pkg::NODE_W-1:0]    na_q;
  logic [kufef_pkg::NODE_W-1:0]    nb_q;
  logic [kufef_pkg::COST_W-1:0]    cost_q;
  logic                            keep_q;
  logic                            res_emitted;
  logic                            res_joined;

  logic                            out_valid;
  logic                            out_emitted;
  logic                            out_joined;
  logic [kufef_pkg::NODE_W-1:0]    out_na;
  logic [kufef_pkg::NODE_W-1:0]    out_nb;
  logic [kufef_pkg::TOTAL_W-1:0]   out_total;

  logic                            ram_we;
  logic [kufef_pkg::ADDR_W-1:0]    ram_waddr;
  logic [kufef_pkg::NODE_W-1:0]    ram_wdata;
  logic [kufef_pkg::ADDR_W-1:0]    ram_raddr;
  logic [kufef_pkg::NODE_W-1:0]    ram_rdata;

  logic                            in_fire;
  logic                            out_free;
  logic                            in_range;
  logic [kufef_pkg::TOTAL_W:0]     sum;
  logic [kufef_pkg::TOTAL_W-1:0]   total_next;

  assign in_edge.ready  = (state == S_IDLE);
  assign in_fire        = in_edge.valid && in_edge.ready;
  assign out_free       = !out_valid || out_result.ready;
  assign in_range       = (32'(in_edge.node_a) < kufef_pkg::NODE_COUNT) &&
                          (32'(in_edge.node_b) < kufef_pkg::NODE_COUNT);
  assign sum            = {1'b0, cost_total} + (kufef_pkg::TOTAL_W + 1)'(cost_q);
  assign total_next     = sum[kufef_pkg::TOTAL_W] ? '1 : sum[kufef_pkg::TOTAL_W-1:0];

  assign out_result.valid             = out_valid;
  assign out_result.edge_emitted      = out_emitted;
  assign out_result.components_joined = out_joined;
  assign out_result.out_node_a        = out_na;
  assign out_result.out_node_b        = out_nb;
  assign out_result.total_cost        = out_total;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = kufef_pkg::node_addr(v);
    ram_wdata = ram_rdata;
    ram_raddr = kufef_pkg::node_addr(v);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = kufef_pkg::NODE_W'(clr_cnt);
      end
      S_IDLE: begin
        ram_raddr = kufef_pkg::node_addr(in_edge.node_a);
      end
      S_WT_V: begin
        if (ram_rdata == v) begin
          if (!phase) begin
            ram_raddr = kufef_pkg::node_addr(nb_q);
          end else if (ra != v) begin
            ram_we    = 1'b1;
            ram_waddr = kufef_pkg::node_addr(ra);
            ram_wdata = v;
          end
        end else begin
          ram_raddr = kufef_pkg::node_addr(ram_rdata);
        end
      end
      S_WT_P: begin
        // halve: parent[v] <= grandparent, continue from grandparent
        ram_we    = 1'b1;
        ram_waddr = kufef_pkg::node_addr(v);
        ram_wdata = ram_rdata;
        ram_raddr = kufef_pkg::node_addr(ram_rdata);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      sweep_after  <= 1'b0;
      natural_mode <= 1'b0;
      cost_total   <= '0;
      out_valid    <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (cfg_we) begin
        natural_mode <= cfg_wdata;
      end
      if (out_valid && out_result.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_cnt == kufef_pkg::ADDR_W'(kufef_pkg::NODE_COUNT - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            na_q        <= in_edge.node_a;
            nb_q        <= in_edge.node_b;
            cost_q      <= in_edge.edge_cost;
            keep_q      <= in_edge.keep_if_cycle;
            res_emitted <= 1'b0;
            res_joined  <= 1'b0;
            sweep_after <= (in_edge.command == kufef_pkg::CMD_CLEAR);
            v           <= in_edge.node_a;
            phase       <= 1'b0;
            if (in_edge.command == kufef_pkg::CMD_CLEAR) begin
              cost_total  <= '0;
              state       <= S_OUT;
            end else if (!in_range) begin
              state <= S_OUT;
            end else begin
              state <= S_WT_V;
            end
          end
        end
        S_WT_V: begin
          if (ram_rdata == v) begin
            if (!phase) begin
              ra    <= v;
              v     <= nb_q;
              phase <= 1'b1;
            end else begin
              if (ra != v) begin
                cost_total  <= total_next;
                res_emitted <= 1'b1;
                res_joined  <= 1'b1;
              end else begin
                res_emitted <= natural_mode && keep_q;
              end
              state <= S_OUT;
            end
          end else begin
            state <= S_WT_P;
          end
        end
        S_WT_P: begin
          v     <= ram_rdata;
          state <= S_WT_V;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_emitted <= res_emitted;
            out_joined  <= res_joined;
            out_na      <= na_q;
            out_nb      <= nb_q;
            out_total   <= cost_total;
            state       <= sweep_after ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  kufef_ram #(
    .WIDTH (kufef_pkg::NODE_W),
    .DEPTH (kufef_pkg::NODE_COUNT)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/edge_filter_checker.sv
// Prediction and comparison for the Kruskal union-find edge filter.
// Watches the request, result and register ports and reports mismatches.
// Depends on kufef_pkg and the kufef_edge_if / kufef_result_if interfaces.
module edge_filter_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  kufef_edge_if          edge_mon,
  kufef_result_if        result_mon,
  output int             fail_count,
  output int             pending
);

  typedef struct packed {
    logic                          emitted;
    logic                          joined;
    logic [kufef_pkg::NODE_W-1:0]  node_a;
    logic [kufef_pkg::NODE_W-1:0]  node_b;
    logic [kufef_pkg::TOTAL_W-1:0] total;
  } filter_result_t;

  logic [kufef_pkg::NODE_W-1:0]  parent_of [kufef_pkg::NODE_COUNT];
  logic [kufef_pkg::TOTAL_W-1:0] cost_total;
  logic                          natural_mode;
  filter_result_t                expected_filter_results [$];
  filter_result_t                oldest;
  int                            mismatch_total = 0;
  int                            backlog = 0;

  assign fail_count = mismatch_total;
  assign pending    = backlog;

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("edge filter mismatch: %s", msg);
  endtask

  task automatic enqueue_expected(input filter_result_t item);
    expected_filter_results.insert(expected_filter_results.size(), item);
  endtask

  function automatic logic [kufef_pkg::NODE_W-1:0] root_of(
    input logic [kufef_pkg::NODE_W-1:0] node);
    logic [kufef_pkg::NODE_W-1:0] v;
    v = node;
    while (parent_of[v] != v) begin
      parent_of[v] = parent_of[parent_of[v]];
      v = parent_of[v];
    end
    return v;
  endfunction

  function automatic filter_result_t predict_filter_result(
    input logic cmd, input logic [kufef_pkg::NODE_W-1:0] a,
    input logic [kufef_pkg::NODE_W-1:0] b,
    input logic [kufef_pkg::COST_W-1:0] cost, input logic keep);
    filter_result_t r;
    logic [kufef_pkg::NODE_W-1:0] root_a, root_b;
    logic [kufef_pkg::TOTAL_W-1:0] wide_cost;
    r = '0;
    r.node_a = a;
    r.node_b = b;
    wide_cost = kufef_pkg::TOTAL_W'(cost);
    if (cmd == kufef_pkg::CMD_CLEAR) begin
      for (int i = 0; i < kufef_pkg::NODE_COUNT; i++) parent_of[i] = kufef_pkg::NODE_W'(i);
      cost_total = '0;
    end else if (int'(a) < kufef_pkg::NODE_COUNT && int'(b) < kufef_pkg::NODE_COUNT) begin
      root_a = root_of(a);
      root_b = root_of(b);
      if (root_a != root_b) begin
        parent_of[root_a] = root_b;
        if (cost_total > ({kufef_pkg::TOTAL_W{1'b1}} - wide_cost)) cost_total = '1;
        else cost_total = cost_total + wide_cost;
        r.emitted = 1'b1;
        r.joined  = 1'b1;
      end else if (natural_mode && keep) begin
        r.emitted = 1'b1;
      end
    end
    r.total = cost_total;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kufef_pkg::NODE_COUNT; i++) parent_of[i] = kufef_pkg::NODE_W'(i);
      cost_total   = '0;
      natural_mode = 1'b0;
      expected_filter_results.delete();
    end else begin
      if (cfg_we) natural_mode = cfg_wdata;
      if (result_mon.valid && result_mon.ready) begin
        if (expected_filter_results.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d with no request outstanding",
                                    result_mon.out_node_a, result_mon.out_node_b));
        end else begin
          oldest = expected_filter_results.pop_front();
          if (result_mon.edge_emitted !== oldest.emitted)
            report_mismatch($sformatf("edge_emitted got %0b expected %0b (%0d-%0d)",
              result_mon.edge_emitted, oldest.emitted, oldest.node_a, oldest.node_b));
          if (result_mon.components_joined !== oldest.joined)
            report_mismatch($sformatf("components_joined got %0b expected %0b (%0d-%0d)",
              result_mon.components_joined, oldest.joined, oldest.node_a, oldest.node_b));
          if (result_mon.out_node_a !== oldest.node_a)
            report_mismatch($sformatf("out_node_a got %0d expected %0d",
              result_mon.out_node_a, oldest.node_a));
          if (result_mon.out_node_b !== oldest.node_b)
            report_mismatch($sformatf("out_node_b got %0d expected %0d",
              result_mon.out_node_b, oldest.node_b));
          if (result_mon.total_cost !== oldest.total)
            report_mismatch($sformatf("total_cost got %0d expected %0d (%0d-%0d)",
              result_mon.total_cost, oldest.total, oldest.node_a, oldest.node_b));
        end
      end
      if (edge_mon.valid && edge_mon.ready)
        enqueue_expected(predict_filter_result(edge_mon.command,
          edge_mon.node_a, edge_mon.node_b, edge_mon.edge_cost, edge_mon.keep_if_cycle));
    end
    backlog <= expected_filter_results.size();
  end

endmodule

>>> tb/kruskal_union_find_edge_filter_test.sv
// Stimulus and verdict for the Kruskal union-find edge filter.
// Drives edge and clear requests, register writes and result back-pressure.
// Depends on kufef_pkg, the kufef interfaces, the block and edge_filter_checker.
module kruskal_union_find_edge_filter_test;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PHASE_ITEMS    = 270;
  localparam int HOLD_CYCLES    = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b0;
  bit   hold_request = 1'b0;

  kufef_edge_if   in_edge ();
  kufef_result_if out_result ();

  kruskal_union_find_edge_filter u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_edge    (in_edge),
    .out_result (out_result)
  );

  edge_filter_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .edge_mon   (in_edge),
    .result_mon (out_result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (in_edge.valid && in_edge.ready) || (out_result.valid && out_result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("kruskal_union_find_edge_filter verification failed");
      $finish;
    end
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_result.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_result.ready <= 1'b0;
      end else begin
        out_result.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [kufef_pkg::NODE_W-1:0] a,
                              input logic [kufef_pkg::NODE_W-1:0] b,
                              input logic [kufef_pkg::COST_W-1:0] cost,
                              input logic keep);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_edge.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_edge.valid         <= 1'b1;
    in_edge.command       <= cmd;
    in_edge.node_a        <= a;
    in_edge.node_b        <= b;
    in_edge.edge_cost     <= cost;
    in_edge.keep_if_cycle <= keep;
    @(posedge clk);
    while (!in_edge.ready) @(posedge clk);
  endtask

  task automatic settle_and_configure(input logic mode);
    in_edge.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (kufef_pkg::NODE_COUNT + 16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_edge_stream(input int count, input bit with_hold, input bit idle_phase);
    int span;
    int pick;
    int step;
    int spans [3];
    logic [kufef_pkg::COST_W-1:0] cost_cursor;
    spans = '{8, 32, kufef_pkg::NODE_COUNT};
    span = kufef_pkg::NODE_COUNT;
    cost_cursor = kufef_pkg::COST_W'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = idle_phase && ($urandom_range(0, 3) != 0);
      if (with_hold && i == count / 3) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_request(kufef_pkg::CMD_CLEAR, kufef_pkg::NODE_W'($urandom),
                     kufef_pkg::NODE_W'($urandom), kufef_pkg::COST_W'($urandom),
                     1'($urandom));
        span = spans[$urandom_range(0, 2)];
        cost_cursor = kufef_pkg::COST_W'($urandom_range(0, 60000));
      end else if (pick < 10) begin
        send_request(kufef_pkg::CMD_EDGE, kufef_pkg::NODE_W'($urandom),
                     kufef_pkg::NODE_W'($urandom), kufef_pkg::COST_W'($urandom),
                     1'($urandom));
      end else begin
        step = $urandom_range(0, 300);
        if (int'(cost_cursor) > 65535 - step) cost_cursor = '1;
        else cost_cursor = cost_cursor + kufef_pkg::COST_W'(step);
        send_request(kufef_pkg::CMD_EDGE, kufef_pkg::NODE_W'($urandom_range(0, span - 1)),
                     kufef_pkg::NODE_W'($urandom_range(0, span - 1)), cost_cursor,
                     1'($urandom));
      end
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= 1'b0;
    in_edge.valid         <= 1'b0;
    in_edge.command       <= kufef_pkg::CMD_EDGE;
    in_edge.node_a        <= '0;
    in_edge.node_b        <= '0;
    in_edge.edge_cost     <= '0;
    in_edge.keep_if_cycle <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // strict spanning tree
    settle_and_configure(1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd0, 10'd1023, 16'd0, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd1023, 10'd0, 16'd1, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd512, 10'd512, 16'd2, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd1, 10'd2, 16'd65535, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd2, 10'd0, 16'd65535, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd1, 10'd1023, 16'd65535, 1'b1);
    send_request(kufef_pkg::CMD_CLEAR, 10'd1023, 10'd1023, 16'd65535, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd0, 10'd1023, 16'd100, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd3, 10'd4, 16'd101, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd4, 10'd5, 16'd102, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd5, 10'd6, 16'd103, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd6, 10'd7, 16'd104, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd3, 10'd7, 16'd105, 1'b1);

    // cycle-closing edges follow the keep bit
    settle_and_configure(1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd7, 10'd3, 16'd106, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd4, 10'd6, 16'd107, 1'b0);
    send_request(kufef_pkg::CMD_EDGE, 10'd0, 10'd0, 16'd108, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd10, 10'd11, 16'd109, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd11, 10'd10, 16'd110, 1'b1);
    send_request(kufef_pkg::CMD_CLEAR, 10'd0, 10'd1023, 16'd0, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd1023, 10'd1023, 16'd0, 1'b1);
    send_request(kufef_pkg::CMD_EDGE, 10'd0, 10'd1023, 16'd65535, 1'b1);

    settle_and_configure(1'b0);
    run_edge_stream(PHASE_ITEMS, 1'b0, 1'b1);
    settle_and_configure(1'b1);
    run_edge_stream(PHASE_ITEMS, 1'b1, 1'b1);
    settle_and_configure(1'b0);
    run_edge_stream(PHASE_ITEMS, 1'b0, 1'b1);
    settle_and_configure(1'b1);
    run_edge_stream(PHASE_ITEMS, 1'b0, 1'b0);

    in_edge.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("kruskal_union_find_edge_filter verification clean");
    end else begin
      $display("kruskal_union_find_edge_filter verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/kufef_pkg.sv
sv/kufef_if.sv
sv/kufef_ram.sv
sv/kruskal_union_find_edge_filter.sv
tb/edge_filter_checker.sv
tb/kruskal_union_find_edge_filter_test.sv
